/* sv/cble_pkg.sv */
// Shared types and constants of the CAN bus load estimator.
// No dependencies; every other file imports this package.
package cble_pkg;

   localparam int unsigned RateWidth   = 20;
   localparam int unsigned WindowWidth = 24;
   localparam int unsigned LoadWidth   = 8;
   localparam int unsigned BpwWidth    = 18;
   localparam int unsigned LenWidth    = 4;
   localparam int unsigned AddWidth    = 8;
   localparam int unsigned NumWidth    = 31;

   localparam logic [RateWidth-1:0]   RateReset    = 20'd500000;
   localparam logic [BpwWidth-1:0]    FallbackBpw  = 18'd125000;
   localparam logic [AddWidth-1:0]    FrameBase    = 8'd41;
   localparam logic [AddWidth-1:0]    BitsPerByte  = 8'd9;
   localparam logic [AddWidth-1:0]    ExtIdBits    = 8'd18;
   localparam logic [6:0]             PercentScale = 7'd100;
   localparam logic [WindowWidth-1:0] WindowMax    = 24'hFFFFFF;

   // Operation codes of an input item.
   localparam logic OpFrame     = 1'b0;
   localparam logic OpWindowEnd = 1'b1;

   // Classified command handed from the front to the back.
   typedef struct packed {
      logic                is_window;
      logic [AddWidth-1:0] add_bits;
   } cmd_type;

   // Status of the command queue.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* sv/can_bus_load_estimator_core.sv */
// CAN bus load estimator, top level.
// Depends on cble_pkg, cble_front, cble_queue and cble_back.
//
// Usage:
//   Request side is a queue: drive req_op, req_data_bytes, req_extended_id
//   and raise req_push; the beat is taken on a clock edge with req_full low.
//   A frame beat (op 0) adds its estimated bit length to the window; a
//   window-end beat (op 1) yields one result.
//   Result side is a queue too: while rsp_empty is low the oldest result is
//   on rsp_load_percent / rsp_traffic_seen; raise rsp_pop to take it.
//   csr_valid/csr_data writes the nominal bit rate; csr_ready is always high.
//   A new rate is taken up when the next window-end result is formed and applies to the window after it.
// Timing:
//   Frame beats are absorbed one per cycle while the back end is idle. A
//   window-end beat occupies the back end through accept, saturation check,
//   eight steps of the restoring divider and blend, skipping the divider
//   when the load saturates; the result shows once the blend is done, after
//   any commands queued ahead of it. The two-entry command queue keeps
//   taking beats meanwhile until it is full.
// Reset:
//   Synchronous, active high. Clears queue, window and smoothed load; rate
//   returns to 500000 bit/s. If the receiver stalls, the result is held and
//   the next window end waits in the back end until the result is popped.
module can_bus_load_estimator_core import cble_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_op,
   input  logic [LenWidth-1:0]  req_data_bytes,
   input  logic                 req_extended_id,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [LoadWidth-1:0] rsp_load_percent,
   output logic                 rsp_traffic_seen,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [RateWidth-1:0] csr_data
);

   queue_status_type q_status;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   logic             q_push;
   logic             q_pop;

   // Classify and push request beats.
   cble_front u_front (
      .req_push        (req_push),
      .req_full        (req_full),
      .req_op          (req_op),
      .req_data_bytes  (req_data_bytes),
      .req_extended_id (req_extended_id),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   // Decouple front and back.
   cble_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // Accumulate, divide, blend and hold the result.
   cble_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_cmd            (head_cmd),
      .q_pop            (q_pop),
      .csr_valid        (csr_valid),
      .csr_data         (csr_data),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_load_percent (rsp_load_percent),
      .rsp_traffic_seen (rsp_traffic_seen)
   );

   // The user must write configuration only while idle (the block does not enforce it), so never back-pressure it.
   assign csr_ready = 1'b1;

endmodule

/* sv/cble_front.sv */
// Front end: accepts input items and classifies them into commands.
// Depends on cble_pkg.
module cble_front import cble_pkg::*; (
   input  logic                    req_push,
   output logic                    req_full,
   input  logic                    req_op,
   input  logic [LenWidth-1:0]     req_data_bytes,
   input  logic                    req_extended_id,
   input  queue_status_type        q_status,
   output logic                    q_push,
   output cmd_type                 q_cmd
);

   logic [AddWidth-1:0] add_bits;

   // Frame length estimate: base, nine per byte, extra for a 29-bit identifier.
   always_comb begin
      add_bits = FrameBase + ({{(AddWidth-LenWidth){1'b0}}, req_data_bytes} * BitsPerByte);
      if (req_extended_id) begin
         add_bits = add_bits + ExtIdBits;
      end
   end

   assign req_full          = q_status.full;
   assign q_push            = req_push && !q_status.full;
   assign q_cmd.is_window   = (req_op == OpWindowEnd);
   assign q_cmd.add_bits    = add_bits;

endmodule

/* sv/cble_queue.sv */
// Two-entry command queue between front and back.
// Depends on cble_pkg.
module cble_queue import cble_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type status
);

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

endmodule

/* sv/cble_back.sv */
// Back end: window accumulator, load division, smoothing and result register.
// Depends on cble_pkg.
module cble_back import cble_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  queue_status_type     q_status,
   input  cmd_type              q_cmd,
   output logic                 q_pop,
   input  logic                 csr_valid,
   input  logic [RateWidth-1:0] csr_data,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [LoadWidth-1:0] rsp_load_percent,
   output logic                 rsp_traffic_seen
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [RateWidth-1:0]   rate_ff, rate_in;
   logic [WindowWidth-1:0] wb_ff, wb_in;
   logic [LoadWidth-1:0]   smooth_ff, smooth_in;
   logic [BpwWidth-1:0]    bpw_ff, bpw_in;
   logic [NumWidth-1:0]    num_ff, num_in;
   logic [BpwWidth-1:0]    div_ff, div_in;
   logic [LoadWidth-1:0]   quot_ff, quot_in;
   logic [2:0]             step_ff, step_in;
   logic                   traffic_ff, traffic_in;
   logic                   out_valid_ff, out_valid_in;
   logic [LoadWidth-1:0]   out_load_ff, out_load_in;
   logic                   out_traffic_ff, out_traffic_in;

   logic [WindowWidth:0]   wb_sum;
   logic [NumWidth-1:0]    trial;
   logic [NumWidth-1:0]    sat_limit;
   logic [9:0]             blend_sum;
   logic [LoadWidth-1:0]   blended;
   logic [BpwWidth-1:0]    reload;

   always_comb begin
      wb_sum    = {1'b0, wb_ff} + {{(WindowWidth+1-AddWidth){1'b0}}, q_cmd.add_bits};
      trial     = {{(NumWidth-BpwWidth){1'b0}}, div_ff} << step_ff;
      sat_limit = {{(NumWidth-BpwWidth-LoadWidth){1'b0}}, div_ff, {LoadWidth{1'b0}}};
      blend_sum = {2'b00, smooth_ff} + {1'b0, smooth_ff, 1'b0} + {2'b00, quot_ff};
      blended   = blend_sum[9:2];
      if (blended == '0 && traffic_ff) begin
         blended = 8'd1;
      end
      reload = rate_ff[RateWidth-1:2];
      if (reload == '0) begin
         reload = FallbackBpw;
      end
   end

   always_comb begin
      state_in       = state_ff;
      rate_in        = rate_ff;
      wb_in          = wb_ff;
      smooth_in      = smooth_ff;
      bpw_in         = bpw_ff;
      num_in         = num_ff;
      div_in         = div_ff;
      quot_in        = quot_ff;
      step_in        = step_ff;
      traffic_in     = traffic_ff;
      out_valid_in   = out_valid_ff;
      out_load_in    = out_load_ff;
      out_traffic_in = out_traffic_ff;
      q_pop          = 1'b0;

      if (csr_valid) begin
         rate_in = csr_data;
      end
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop = 1'b1;
               if (q_cmd.is_window) begin
                  // Latch the scaled window and open a fresh one.
                  num_in     = NumWidth'(wb_ff) * NumWidth'(PercentScale);
                  div_in     = bpw_ff;
                  traffic_in = (wb_ff != '0);
                  wb_in      = '0;
                  state_in   = ST_CHECK;
               end else if (wb_sum > {1'b0, WindowMax}) begin
                  wb_in = WindowMax;
               end else begin
                  wb_in = wb_sum[WindowWidth-1:0];
               end
            end
         end
         ST_CHECK: begin
            quot_in = '0;
            if (num_ff >= sat_limit) begin
               quot_in  = '1;
               state_in = ST_FINISH;
            end else begin
               step_in  = 3'd7;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (num_ff >= trial) begin
               num_in           = num_ff - trial;
               quot_in[step_ff] = 1'b1;
            end
            step_in = step_ff - 3'd1;
            if (step_ff == 3'd0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the result register is free.
            if (!out_valid_ff) begin
               smooth_in      = blended;
               bpw_in         = reload;
               out_valid_in   = 1'b1;
               out_load_in    = blended;
               out_traffic_in = traffic_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= RateReset;
         wb_ff        <= '0;
         smooth_ff    <= '0;
         bpw_ff       <= RateReset[RateWidth-1:2];
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         wb_ff        <= wb_in;
         smooth_ff    <= smooth_in;
         bpw_ff       <= bpw_in;
         out_valid_ff <= out_valid_in;
      end
      num_ff         <= num_in;
      div_ff         <= div_in;
      quot_ff        <= quot_in;
      step_ff        <= step_in;
      traffic_ff     <= traffic_in;
      out_load_ff    <= out_load_in;
      out_traffic_ff <= out_traffic_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_load_percent = out_load_ff;
   assign rsp_traffic_seen = out_traffic_ff;

endmodule

/* sv/cble_checker.sv */
// Port-level checks of the CAN bus load estimator, bound to the top level.
// Depends on cble_pkg and can_bus_load_estimator_core.
module cble_checker import cble_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_full,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input logic [LoadWidth-1:0] rsp_load_percent,
   input logic                 rsp_traffic_seen
);

   // Reset drains both queues.
   assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // One result slot: a popped result is never replaced in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop) |=> rsp_empty)
      else $error("result replaced on pop");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_load_percent) && $stable(rsp_traffic_seen)))
      else $error("stalled result changed");

   // Traffic in the window forces a non-zero load.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_traffic_seen) |-> (rsp_load_percent != '0))
      else $error("traffic seen with zero load");

endmodule

bind can_bus_load_estimator_core cble_checker u_cble_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_load_percent (rsp_load_percent),
   .rsp_traffic_seen (rsp_traffic_seen)
);
